[sv/assert_macros.svh]
// Assertion macros shared by the RTL that checks its own control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[sv/tld_pkg.sv]
// Types and character constants of the terminal line discipline.
`timescale 1ns / 1ps

package tld_pkg;

    localparam logic [1:0] CMD_RX    = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [1:0] RS_OK        = 2'd0;
    localparam logic [1:0] RS_NOT_READY = 2'd1;
    localparam logic [1:0] RS_EMPTY     = 2'd2;

    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd1;
    localparam logic [1:0] SIG_STOP = 2'd2;

    localparam logic [7:0] CH_INTR  = 8'h03;
    localparam logic [7:0] CH_STOP  = 8'h1a;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UC_C  = 8'h43;
    localparam logic [7:0] CH_UC_Z  = 8'h5a;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic       chunk_end;
    } t_in_item;

    typedef struct packed {
        logic        echo_valid;
        logic [7:0]  echo_char;
        logic [1:0]  signal_kind;
        logic        wake_readers;
        logic [1:0]  read_status;
        logic [7:0]  read_char;
        logic        line_ready;
        logic [10:0] fill_level;
        logic        last_of_run;
    } t_out_item;

    // Everything one processed item leaves for the output side.
    typedef struct packed {
        logic [2:0][7:0] echo;
        logic [1:0]      echo_n;
        logic [1:0]      signal_kind;
        logic            wake;
        logic [1:0]      read_status;
        logic            read_ok;
        logic            line_ready;
        logic [10:0]     fill_level;
    } t_res_rec;

endpackage

[sv/tld_edit.sv]
// Next-state and result logic for one item of the line discipline.
`timescale 1ns / 1ps

module tld_edit #(
    parameter int LINE_DEPTH = 1024,
    parameter int IDX_W      = $clog2(LINE_DEPTH),
    parameter int CNT_W      = $clog2(LINE_DEPTH + 1)
) (
    input  tld_pkg::t_in_item i_item,
    input  logic              i_pass_thru,
    input  logic [IDX_W-1:0]  i_head,
    input  logic [CNT_W-1:0]  i_count,
    input  logic              i_ready,
    input  logic              i_discard,
    output logic [IDX_W-1:0]  o_head,
    output logic [CNT_W-1:0]  o_count,
    output logic              o_ready,
    output logic              o_discard,
    output logic              o_wr_en,
    output logic [IDX_W-1:0]  o_wr_addr,
    output logic [7:0]        o_wr_data,
    output tld_pkg::t_res_rec o_rec
);

    localparam int SUM_W = CNT_W + 1;

    always_comb begin
        logic [IDX_W-1:0] h;
        logic [CNT_W-1:0] cnt;
        logic             rdy;
        logic             disc;
        logic             stop;
        logic             do_store;
        logic [7:0]       c;
        logic [SUM_W-1:0] pos;

        h        = i_head;
        cnt      = i_count;
        rdy      = i_ready;
        disc     = i_discard;
        stop     = 1'b0;
        do_store = 1'b0;
        c        = i_item.rx_byte;
        pos      = '0;

        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = '0;
        o_rec     = '0;

        case (i_item.cmd)
            tld_pkg::CMD_RX: begin
                if (disc) begin
                    if (i_item.chunk_end) begin
                        disc = 1'b0;
                    end
                end else begin
                    if (c == tld_pkg::CH_INTR || c == tld_pkg::CH_STOP) begin
                        o_rec.signal_kind = (c == tld_pkg::CH_INTR) ?
                                            tld_pkg::SIG_INTR : tld_pkg::SIG_STOP;
                        h   = '0;
                        cnt = '0;
                        rdy = 1'b0;
                        if (i_pass_thru) begin
                            do_store = 1'b1;
                            rdy      = 1'b1;
                        end else begin
                            o_rec.echo[0] = tld_pkg::CH_CARET;
                            o_rec.echo[1] = (c == tld_pkg::CH_INTR) ?
                                            tld_pkg::CH_UC_C : tld_pkg::CH_UC_Z;
                            o_rec.echo[2] = tld_pkg::CH_LF;
                            o_rec.echo_n  = 2'd3;
                        end
                    end else if (i_pass_thru) begin
                        do_store = 1'b1;
                        rdy      = 1'b1;
                    end else if (c == tld_pkg::CH_BS || c == tld_pkg::CH_DEL) begin
                        if (cnt != '0) begin
                            cnt           = cnt - CNT_W'(1);
                            o_rec.echo[0] = tld_pkg::CH_BS;
                            o_rec.echo[1] = tld_pkg::CH_SPACE;
                            o_rec.echo[2] = tld_pkg::CH_BS;
                            o_rec.echo_n  = 2'd3;
                        end
                    end else if (cnt == CNT_W'(LINE_DEPTH)) begin
                        rdy  = 1'b1;
                        stop = 1'b1;
                    end else begin
                        if (c == tld_pkg::CH_CR) begin
                            c = tld_pkg::CH_LF;
                        end
                        o_rec.echo[0] = c;
                        o_rec.echo_n  = 2'd1;
                        do_store      = 1'b1;
                        if (c == tld_pkg::CH_LF) begin
                            rdy  = 1'b1;
                            stop = 1'b1;
                        end
                    end

                    // The write slot sits count bytes past the head, modulo the depth.
                    if (do_store && cnt < CNT_W'(LINE_DEPTH)) begin
                        pos = SUM_W'(h) + SUM_W'(cnt);
                        if (pos >= SUM_W'(LINE_DEPTH)) begin
                            pos = pos - SUM_W'(LINE_DEPTH);
                        end
                        o_wr_en   = 1'b1;
                        o_wr_addr = pos[IDX_W-1:0];
                        o_wr_data = c;
                        cnt       = cnt + CNT_W'(1);
                    end

                    if (stop || i_item.chunk_end) begin
                        o_rec.wake = rdy;
                    end
                    if (stop && !i_item.chunk_end) begin
                        disc = 1'b1;
                    end
                end
            end
            tld_pkg::CMD_READ: begin
                if (!rdy) begin
                    o_rec.read_status = tld_pkg::RS_NOT_READY;
                end else if (cnt == '0) begin
                    o_rec.read_status = tld_pkg::RS_EMPTY;
                    rdy               = 1'b0;
                end else begin
                    o_rec.read_status = tld_pkg::RS_OK;
                    o_rec.read_ok     = 1'b1;
                    h   = (h == IDX_W'(LINE_DEPTH - 1)) ? '0 : h + IDX_W'(1);
                    cnt = cnt - CNT_W'(1);
                    if (cnt == '0) begin
                        rdy = 1'b0;
                    end
                end
            end
            tld_pkg::CMD_FLUSH: begin
                h   = '0;
                cnt = '0;
                rdy = 1'b0;
            end
            default: begin
            end
        endcase

        o_rec.line_ready = rdy;
        o_rec.fill_level = 11'(cnt);
        o_head    = h;
        o_count   = cnt;
        o_ready   = rdy;
        o_discard = disc;
    end

endmodule

[sv/tty_line_discipline_unit.sv]
// Top level of the terminal line discipline: channels, line store and result sequencing.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one command per transfer:
// a received byte with its end-of-chunk mark, a one-byte read, or a line flush.
// Output channel (o_out_valid / i_out_ready / o_out_data) gives one to three results
// per command; last_of_run marks the final one. Echo sequences (caret text, erase)
// give three results, a plain canonical byte gives one, everything else one.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
// pass-through mode bit; it is always ready and is meant to be written while idle.
// A command is held in the input register until the result register is free and
// then offers its first result from there. Throughput: one command per cycle for
// single-result commands while the receiver takes every result; a command that
// echoes three characters holds the result register for three output transfers,
// so the sustained pace is set by the number of results each command gives.
// The line store is a single-port-write, single-read memory; a read command
// fetches its byte in the same cycle that the command is evaluated.
// A stalled receiver holds the current result; one further command waits in the
// input register, after which o_in_ready drops.
// Reset clears the line state, the mode and both handshake stages; the contents
// of the line store are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tty_line_discipline_unit #(
    parameter int LINE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tld_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tld_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    localparam int IDX_W = $clog2(LINE_DEPTH);
    localparam int CNT_W = $clog2(LINE_DEPTH + 1);

    logic [7:0] r_mem [LINE_DEPTH];

    tld_pkg::t_in_item r_in;
    logic              r_in_valid;
    tld_pkg::t_res_rec r_rec;
    logic              r_res_valid;
    logic [1:0]        r_idx;
    logic [7:0]        r_rd_char;
    logic [IDX_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_count;
    logic              r_ready;
    logic              r_discard;
    logic              r_pass_thru;

    logic [IDX_W-1:0]  n_head;
    logic [CNT_W-1:0]  n_count;
    logic              n_ready;
    logic              n_discard;
    tld_pkg::t_res_rec n_rec;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [7:0]        wr_data;

    logic       in_fire;
    logic       out_fire;
    logic       proc;
    logic       slot_free;
    logic       res_last;
    logic [1:0] last_idx;

    tld_edit #(
        .LINE_DEPTH (LINE_DEPTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_edit (
        .i_item      (r_in),
        .i_pass_thru (r_pass_thru),
        .i_head      (r_head),
        .i_count     (r_count),
        .i_ready     (r_ready),
        .i_discard   (r_discard),
        .o_head      (n_head),
        .o_count     (n_count),
        .o_ready     (n_ready),
        .o_discard   (n_discard),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rec       (n_rec)
    );

    assign last_idx  = (r_rec.echo_n == 2'd0) ? 2'd0 : r_rec.echo_n - 2'd1;
    assign res_last  = (r_idx == last_idx);
    assign out_fire  = o_out_valid && i_out_ready;
    assign slot_free = !r_res_valid || (out_fire && res_last);
    assign proc      = r_in_valid && slot_free;
    assign o_in_ready  = !r_in_valid || proc;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_res_valid;

    always_comb begin
        o_out_data              = '0;
        o_out_data.echo_valid   = (r_idx < r_rec.echo_n);
        o_out_data.echo_char    = (r_idx < r_rec.echo_n) ? r_rec.echo[r_idx] : 8'h00;
        o_out_data.signal_kind  = res_last ? r_rec.signal_kind : tld_pkg::SIG_NONE;
        o_out_data.wake_readers = res_last && r_rec.wake;
        o_out_data.read_status  = r_rec.read_status;
        o_out_data.read_char    = r_rec.read_ok ? r_rd_char : 8'h00;
        o_out_data.line_ready   = r_rec.line_ready;
        o_out_data.fill_level   = r_rec.fill_level;
        o_out_data.last_of_run  = res_last;
    end

    // Line store: written by receive commands, read at the head by read commands.
    always_ff @(posedge i_clk) begin
        if (proc && wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (proc) begin
            r_rd_char <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
        if (proc) begin
            r_rec <= n_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_head      <= '0;
            r_count     <= '0;
            r_ready     <= 1'b0;
            r_discard   <= 1'b0;
            r_pass_thru <= 1'b0;
        end else begin
            r_in_valid  <= in_fire || (r_in_valid && !proc);
            r_res_valid <= proc || (r_res_valid && !(out_fire && res_last));
            if (proc) begin
                r_idx     <= 2'd0;
                r_head    <= n_head;
                r_count   <= n_count;
                r_ready   <= n_ready;
                r_discard <= n_discard;
            end else if (out_fire && !res_last) begin
                r_idx <= r_idx + 2'd1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_pass_thru <= i_cfg_data;
            end
        end
    end

    `ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(LINE_DEPTH))
    `ASSERT_IMP(a_idx_in_run, i_clk, i_rst_n, r_res_valid && r_idx != 2'd0, r_rec.echo_n > r_idx)
    `ASSERT_NEXT(a_stall_holds_idx, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(r_idx))
    `ASSERT_NEXT(a_pending_item_kept, i_clk, i_rst_n, r_in_valid && !proc, r_in_valid)

endmodule

[dv/tty_line_discipline_unit_test.sv]
// Self-checking testbench for the terminal line discipline unit.
`timescale 1ns / 1ps

module tty_line_discipline_unit_test;

    localparam int LINE_DEPTH = 1024;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int MAX_REPORTS = 10;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    tld_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    tld_pkg::t_out_item o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_data = 1'b0;

    tty_line_discipline_unit #(.LINE_DEPTH(LINE_DEPTH)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the line state and the mode.
    logic [7:0]  line_mem [LINE_DEPTH];
    int unsigned line_head = 0;
    int unsigned line_cnt = 0;
    logic        line_rdy = 1'b0;
    logic        skip_chunk = 1'b0;
    logic        raw_on = 1'b0;

    tld_pkg::t_in_item  cmd_q [$];
    tld_pkg::t_out_item due_results [$];
    int        n_posted = 0;
    int        n_bad = 0;
    int        send_idle_pct = 10;
    int        recv_idle_pct = 75;
    int        hold_left = 0;
    int        quiet_cycles = 0;
    logic      in_fire = 1'b0;

    function automatic void drop_line();
        line_head = 0;
        line_cnt = 0;
        line_rdy = 1'b0;
    endfunction

    function automatic void keep_byte(input logic [7:0] ch);
        int unsigned pos;
        if (line_cnt >= LINE_DEPTH) return;
        pos = (line_head + line_cnt) % LINE_DEPTH;
        line_mem[pos] = ch;
        line_cnt++;
    endfunction

    // Applies one command to the shadow state and queues the results it gives.
    function automatic void run_tty_cmd(input tld_pkg::t_in_item it);
        logic [7:0]         echo_buf [3];
        int                 n_echo;
        int                 n_res;
        int                 k;
        logic [7:0]         ch;
        logic [1:0]         sig;
        logic [1:0]         rs;
        logic [7:0]         rc;
        logic               wake;
        logic               brk;
        logic               last;
        tld_pkg::t_out_item r;
        n_echo = 0;
        sig = tld_pkg::SIG_NONE;
        rs = tld_pkg::RS_OK;
        rc = 8'h00;
        wake = 1'b0;
        brk = 1'b0;
        ch = it.rx_byte;
        case (it.cmd)
            tld_pkg::CMD_RX: begin
                if (skip_chunk) begin
                    if (it.chunk_end) skip_chunk = 1'b0;
                end else begin
                    if (ch == tld_pkg::CH_INTR || ch == tld_pkg::CH_STOP) begin
                        sig = (ch == tld_pkg::CH_INTR) ? tld_pkg::SIG_INTR : tld_pkg::SIG_STOP;
                        drop_line();
                        if (raw_on) begin
                            keep_byte(ch);
                            line_rdy = 1'b1;
                        end else begin
                            echo_buf[0] = tld_pkg::CH_CARET;
                            echo_buf[1] = (ch == tld_pkg::CH_INTR) ?
                                          tld_pkg::CH_UC_C : tld_pkg::CH_UC_Z;
                            echo_buf[2] = tld_pkg::CH_LF;
                            n_echo = 3;
                        end
                    end else if (raw_on) begin
                        keep_byte(ch);
                        line_rdy = 1'b1;
                    end else if (ch == tld_pkg::CH_BS || ch == tld_pkg::CH_DEL) begin
                        if (line_cnt > 0) begin
                            line_cnt--;
                            echo_buf[0] = tld_pkg::CH_BS;
                            echo_buf[1] = tld_pkg::CH_SPACE;
                            echo_buf[2] = tld_pkg::CH_BS;
                            n_echo = 3;
                        end
                    end else if (line_cnt >= LINE_DEPTH) begin
                        line_rdy = 1'b1;
                        brk = 1'b1;
                    end else begin
                        if (ch == tld_pkg::CH_CR) ch = tld_pkg::CH_LF;
                        echo_buf[0] = ch;
                        n_echo = 1;
                        keep_byte(ch);
                        if (ch == tld_pkg::CH_LF) begin
                            line_rdy = 1'b1;
                            brk = 1'b1;
                        end
                    end
                    if (brk || it.chunk_end) wake = line_rdy;
                    // A line break or a full line inside a chunk throws away the rest of that chunk.
                    if (brk && !it.chunk_end) skip_chunk = 1'b1;
                end
            end
            tld_pkg::CMD_READ: begin
                if (!line_rdy) begin
                    rs = tld_pkg::RS_NOT_READY;
                end else if (line_cnt == 0) begin
                    rs = tld_pkg::RS_EMPTY;
                    line_rdy = 1'b0;
                end else begin
                    rc = line_mem[line_head];
                    line_head = (line_head + 1) % LINE_DEPTH;
                    line_cnt--;
                    if (line_cnt == 0) line_rdy = 1'b0;
                end
            end
            tld_pkg::CMD_FLUSH: drop_line();
            default: ;
        endcase
        n_res = (n_echo > 0) ? n_echo : 1;
        for (k = 0; k < n_res; k++) begin
            last = (k == n_res - 1);
            r.echo_valid   = (k < n_echo);
            r.echo_char    = (k < n_echo) ? echo_buf[k] : 8'h00;
            r.signal_kind  = last ? sig : tld_pkg::SIG_NONE;
            r.wake_readers = last ? wake : 1'b0;
            r.read_status  = rs;
            r.read_char    = rc;
            r.line_ready   = line_rdy;
            r.fill_level   = 11'(line_cnt);
            r.last_of_run  = last;
            due_results.push_back(r);
        end
    endfunction

    function automatic string show_result(input tld_pkg::t_out_item r);
        return $sformatf("echo %0b/%h sig %0d wake %0b rs %0d rc %h rdy %0b fill %0d last %0b",
            r.echo_valid, r.echo_char, r.signal_kind, r.wake_readers, r.read_status,
            r.read_char, r.line_ready, r.fill_level, r.last_of_run);
    endfunction

    // Input side: note each transfer and predict its results.
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        if (in_fire) run_tty_cmd(i_in_data);
    end

    // Output side: compare each transfer with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        tld_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("unexpected result: %s", show_result(o_out_data));
            end else begin
                want = due_results.pop_front();
                if (o_out_data.echo_valid !== want.echo_valid ||
                    o_out_data.echo_char !== want.echo_char ||
                    o_out_data.signal_kind !== want.signal_kind ||
                    o_out_data.wake_readers !== want.wake_readers ||
                    o_out_data.read_status !== want.read_status ||
                    o_out_data.read_char !== want.read_char ||
                    o_out_data.line_ready !== want.line_ready ||
                    o_out_data.fill_level !== want.fill_level ||
                    o_out_data.last_of_run !== want.last_of_run) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS) begin
                        $display("result mismatch at %0t", $realtime);
                        $display("  expected %s", show_result(want));
                        $display("  actual   %s", show_result(o_out_data));
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || in_fire) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= cmd_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // A long hold-off lets the block fill up and push back on its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void post_cmd(input logic [1:0] c, input logic [7:0] b, input logic e);
        tld_pkg::t_in_item it;
        it.cmd = c;
        it.rx_byte = b;
        it.chunk_end = e;
        cmd_q.push_back(it);
        n_posted++;
    endfunction

    task automatic write_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        raw_on = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (cmd_q.size() != 0 || i_in_valid || due_results.size() != 0);
    endtask

    function automatic logic [7:0] pick_rx_byte();
        int p;
        p = $urandom_range(99);
        if (p < 72) return 8'($urandom_range(8'h20, 8'h7e));
        if (p < 84) return ($urandom_range(1) != 0) ? tld_pkg::CH_BS : tld_pkg::CH_DEL;
        if (p < 88) return ($urandom_range(1) != 0) ? tld_pkg::CH_INTR : tld_pkg::CH_STOP;
        return 8'($urandom_range(255));
    endfunction

    // Mostly whole typed lines followed by reads, with loose commands mixed in.
    task automatic add_traffic(input int n_items);
        int         goal;
        int         len;
        int         i;
        int         p;
        logic [1:0] c;
        logic [7:0] b;
        goal = n_posted + n_items;
        while (n_posted < goal) begin
            p = $urandom_range(99);
            if (p < 70) begin
                len = $urandom_range(1, 8);
                for (i = 0; i < len - 1; i++) post_cmd(tld_pkg::CMD_RX, pick_rx_byte(), 1'b0);
                if ($urandom_range(99) < 60)
                    b = ($urandom_range(1) != 0) ? tld_pkg::CH_LF : tld_pkg::CH_CR;
                else
                    b = pick_rx_byte();
                post_cmd(tld_pkg::CMD_RX, b, 1'b1);
                repeat ($urandom_range(0, len + 1))
                    post_cmd(tld_pkg::CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
                if ($urandom_range(99) < 10) post_cmd(tld_pkg::CMD_FLUSH, 8'h00, 1'b0);
            end else begin
                p = $urandom_range(99);
                if (p < 40) c = tld_pkg::CMD_RX;
                else if (p < 80) c = tld_pkg::CMD_READ;
                else if (p < 95) c = tld_pkg::CMD_FLUSH;
                else c = CMD_UNUSED;
                post_cmd(c, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Slow receiver.
        send_idle_pct = 10;
        recv_idle_pct = 75;
        write_mode(1'b0);
        post_cmd(tld_pkg::CMD_RX, 8'h61, 1'b0);
        post_cmd(tld_pkg::CMD_RX, tld_pkg::CH_CR, 1'b0);
        post_cmd(tld_pkg::CMD_RX, 8'h62, 1'b1);
        post_cmd(tld_pkg::CMD_READ, 8'h00, 1'b0);
        post_cmd(tld_pkg::CMD_READ, 8'hff, 1'b1);
        post_cmd(tld_pkg::CMD_READ, 8'h00, 1'b0);
        post_cmd(tld_pkg::CMD_RX, tld_pkg::CH_BS, 1'b1);
        post_cmd(tld_pkg::CMD_RX, 8'hff, 1'b0);
        post_cmd(tld_pkg::CMD_RX, 8'h00, 1'b0);
        post_cmd(tld_pkg::CMD_RX, tld_pkg::CH_DEL, 1'b0);
        post_cmd(tld_pkg::CMD_RX, tld_pkg::CH_INTR, 1'b0);
        post_cmd(tld_pkg::CMD_RX, tld_pkg::CH_STOP, 1'b1);
        post_cmd(tld_pkg::CMD_RX, tld_pkg::CH_LF, 1'b1);
        post_cmd(tld_pkg::CMD_RX, tld_pkg::CH_BS, 1'b1);
        post_cmd(tld_pkg::CMD_READ, 8'h00, 1'b0);
        post_cmd(tld_pkg::CMD_READ, 8'h00, 1'b0);
        post_cmd(tld_pkg::CMD_FLUSH, 8'hff, 1'b1);
        post_cmd(CMD_UNUSED, 8'hff, 1'b1);
        wait_drained();
        write_mode(1'b1);
        post_cmd(tld_pkg::CMD_RX, 8'h00, 1'b0);
        post_cmd(tld_pkg::CMD_RX, 8'hff, 1'b1);
        post_cmd(tld_pkg::CMD_RX, tld_pkg::CH_INTR, 1'b1);
        post_cmd(tld_pkg::CMD_READ, 8'h00, 1'b0);
        post_cmd(tld_pkg::CMD_READ, 8'h00, 1'b0);
        post_cmd(tld_pkg::CMD_RX, tld_pkg::CH_STOP, 1'b0);
        post_cmd(tld_pkg::CMD_RX, tld_pkg::CH_DEL, 1'b1);
        post_cmd(tld_pkg::CMD_FLUSH, 8'h00, 1'b0);
        post_cmd(CMD_UNUSED, 8'h00, 1'b0);
        wait_drained();
        write_mode(1'b0);
        add_traffic(40);
        wait_drained();
        write_mode(1'b1);
        add_traffic(35);
        wait_drained();

        // Slow sender.
        send_idle_pct = 75;
        recv_idle_pct = 10;
        write_mode(1'b0);
        add_traffic(40);
        wait_drained();
        write_mode(1'b1);
        add_traffic(35);
        wait_drained();

        // Full rate, starting with a long output stall.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mode(1'b0);
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        add_traffic(40);
        wait_drained();
        write_mode(1'b1);
        add_traffic(35);
        wait_drained();

        repeat (20) @(posedge i_clk);
        n_bad += due_results.size();
        if (n_bad == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[tty_line_discipline_unit.f]
+incdir+sv
sv/tld_pkg.sv
sv/tld_edit.sv
sv/tty_line_discipline_unit.sv
dv/tty_line_discipline_unit_test.sv
